### rtl/rwwq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rwwq_pkg;

  localparam int unsigned MAX_WAITERS_DEF = 16;
  localparam int unsigned MAX_RESULTS = 16;

  localparam logic [2:0] OP_ENQ = 3'd0;
  localparam logic [2:0] OP_REM = 3'd1;
  localparam logic [2:0] OP_WAKE = 3'd2;
  localparam logic [2:0] OP_PROM = 3'd3;
  localparam logic [2:0] OP_QRY = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] handle;
    logic       is_reader;
    logic [7:0] cv_tag;
    logic       first_only;
  } in_t;

  typedef struct packed {
    logic       woke;
    logic [7:0] woken_handle;
    logic [1:0] status;
    logic       found;
    logic       queue_empty;
    logic       last;
  } out_t;

  // One table entry: handle, done, reader, tag.
  typedef struct packed {
    logic [7:0] handle;
    logic       done;
    logic       reader;
    logic [7:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

### rtl/reader_writer_wait_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Reader/writer wait queue.
// An operation beat is taken when start is high and busy is low. The block
// holds up to MAX_WAITERS waiters in one synchronous memory and walks the
// table one entry per cycle with a read-modify-write sequencer.
// Each result beat is shown for one cycle with out_valid; out_fields.last
// marks the final beat of the operation. Wake may give several beats; a
// woken reader's beat goes out once the next woken reader is found or the
// scan ends, so the final beat can carry last.
// Enqueue, promote with tag zero, unused codes and any scan of an empty
// table go from acceptance straight to the done state. Remove, wake,
// promote and query first read the table and then scan it one entry at a
// time; a remove that closes a gap then moves each later entry down one
// place. busy falls in the cycle that shows the final beat, so the next
// operation can be taken at the edge that ends it.
// Reset clears the count and the sequencer; table contents need no clearing
// because entries at or above the count are never used.
// The receiver cannot stall: each beat is valid for exactly one cycle.
module reader_writer_wait_queue_unit #(
  parameter int unsigned MAX_WAITERS = rwwq_pkg::MAX_WAITERS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire rwwq_pkg::in_t  in_fields,
  output logic                out_valid,
  output rwwq_pkg::out_t      out_fields
);

  localparam int unsigned AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned CW = $clog2(MAX_WAITERS + 1);
  localparam int unsigned RW = $clog2(rwwq_pkg::MAX_RESULTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_WAITERS);
  localparam logic [RW-1:0] MAXR = RW'(rwwq_pkg::MAX_RESULTS);

  rwwq_pkg::entry_t mem [MAX_WAITERS];
  rwwq_pkg::entry_t rdata_r;

  rwwq_pkg::state_t state_r, state_nxt;
  rwwq_pkg::in_t    req_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [RW-1:0]    nres_r, nres_nxt;
  logic             typed_r, typed_nxt, kind_r, kind_nxt;
  logic             hit_r, hit_nxt;
  logic [1:0]       st_r, st_nxt;
  rwwq_pkg::out_t   hold_r, hold_nxt;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  rwwq_pkg::entry_t wdata;
  logic             ov;
  rwwq_pkg::out_t   of;

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rwwq_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    if (start && !busy) begin
      req_r <= in_fields;
    end
    idx_r   <= idx_nxt;
    nres_r  <= nres_nxt;
    typed_r <= typed_nxt;
    kind_r  <= kind_nxt;
    hit_r   <= hit_nxt;
    st_r    <= st_nxt;
    hold_r  <= hold_nxt;
  end

  assign busy = (state_r != rwwq_pkg::S_IDLE);

  // Sequencer: next state and bookkeeping.
  always_comb begin
    logic eligible;
    logic at_end;
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    nres_nxt  = nres_r;
    typed_nxt = typed_r;
    kind_nxt  = kind_r;
    hit_nxt   = hit_r;
    st_nxt    = st_r;
    raddr     = idx_r[AW-1:0];
    eligible  = (rdata_r.tag == 8'd0) && !rdata_r.done &&
                (!typed_r || rdata_r.reader == kind_r);
    at_end    = (idx_r + CW'(1) >= count_r);
    unique case (state_r)
      rwwq_pkg::S_IDLE: begin
        idx_nxt   = '0;
        nres_nxt  = '0;
        typed_nxt = 1'b0;
        hit_nxt   = 1'b0;
        st_nxt    = rwwq_pkg::ST_OK;
        raddr     = '0;
        if (start) begin
          if (in_fields.op == rwwq_pkg::OP_ENQ) begin
            if (count_r < MAXC) begin
              count_nxt = count_r + CW'(1);
            end else begin
              st_nxt = rwwq_pkg::ST_FULL;
            end
            state_nxt = rwwq_pkg::S_DONE;
          end else if (in_fields.op == rwwq_pkg::OP_REM ||
                       in_fields.op == rwwq_pkg::OP_WAKE ||
                       in_fields.op == rwwq_pkg::OP_QRY ||
                       (in_fields.op == rwwq_pkg::OP_PROM && in_fields.cv_tag != 8'd0)) begin
            if (in_fields.op == rwwq_pkg::OP_REM) st_nxt = rwwq_pkg::ST_NOTFOUND;
            state_nxt = (count_r == '0) ? rwwq_pkg::S_DONE : rwwq_pkg::S_READ;
          end else begin
            state_nxt = rwwq_pkg::S_DONE;
          end
        end
      end
      rwwq_pkg::S_READ: begin
        // Read of idx_r is in flight.
        state_nxt = rwwq_pkg::S_SCAN;
      end
      rwwq_pkg::S_SCAN: begin
        // rdata_r holds entry idx_r; next read is idx_r + 1.
        raddr = AW'(idx_r + CW'(1));
        idx_nxt = idx_r + CW'(1);
        state_nxt = at_end ? rwwq_pkg::S_DONE : rwwq_pkg::S_SCAN;
        case (req_r.op)
          rwwq_pkg::OP_REM: begin
            if (rdata_r.handle == req_r.handle) begin
              st_nxt = rdata_r.done ? rwwq_pkg::ST_OK : rwwq_pkg::ST_TIMEOUT;
              count_nxt = count_r - CW'(1);
              state_nxt = at_end ? rwwq_pkg::S_DONE : rwwq_pkg::S_SHIFT;
            end
          end
          rwwq_pkg::OP_WAKE: begin
            if (eligible) begin
              typed_nxt = 1'b1;
              kind_nxt  = typed_r ? kind_r : rdata_r.reader;
              nres_nxt  = nres_r + RW'(1);
              if (!rdata_r.reader || nres_r + RW'(1) >= MAXR) begin
                state_nxt = rwwq_pkg::S_DONE;
              end
            end
          end
          rwwq_pkg::OP_PROM: begin
            if (rdata_r.tag == req_r.cv_tag && req_r.first_only) begin
              state_nxt = rwwq_pkg::S_DONE;
            end
          end
          rwwq_pkg::OP_QRY: begin
            if (rdata_r.tag == req_r.cv_tag) begin
              hit_nxt = 1'b1;
              state_nxt = rwwq_pkg::S_DONE;
            end
          end
          default: ;
        endcase
      end
      rwwq_pkg::S_SHIFT: begin
        // rdata_r holds entry idx_r; it moves down to idx_r - 1.
        raddr = AW'(idx_r + CW'(1));
        idx_nxt = idx_r + CW'(1);
        state_nxt = (idx_r + CW'(1) > count_r) ? rwwq_pkg::S_DONE : rwwq_pkg::S_SHIFT;
      end
      rwwq_pkg::S_DONE: begin
        state_nxt = rwwq_pkg::S_IDLE;
      end
      default: state_nxt = rwwq_pkg::S_IDLE;
    endcase
  end

  // Memory writes and result beats.
  always_comb begin
    logic eligible;
    we       = 1'b0;
    waddr    = idx_r[AW-1:0];
    wdata    = rdata_r;
    ov       = 1'b0;
    of       = '0;
    hold_nxt = hold_r;
    eligible = (rdata_r.tag == 8'd0) && !rdata_r.done &&
               (!typed_r || rdata_r.reader == kind_r);
    unique case (state_r)
      rwwq_pkg::S_IDLE: begin
        if (start && in_fields.op == rwwq_pkg::OP_ENQ && count_r < MAXC) begin
          we    = 1'b1;
          waddr = count_r[AW-1:0];
          wdata = '{handle: in_fields.handle, done: 1'b0,
                    reader: in_fields.is_reader, tag: in_fields.cv_tag};
        end
      end
      rwwq_pkg::S_SCAN: begin
        if (req_r.op == rwwq_pkg::OP_WAKE && eligible) begin
          we = 1'b1;
          wdata.done = 1'b1;
          // The held beat goes out now that another woken waiter follows it.
          ov = (nres_r != '0);
          of = hold_r;
          of.last = 1'b0;
          hold_nxt = '0;
          hold_nxt.woke = 1'b1;
          hold_nxt.woken_handle = rdata_r.handle;
          hold_nxt.status = rwwq_pkg::ST_OK;
          hold_nxt.queue_empty = (count_r == '0);
        end else if (req_r.op == rwwq_pkg::OP_PROM && rdata_r.tag == req_r.cv_tag) begin
          we = 1'b1;
          wdata.tag = 8'd0;
        end
      end
      rwwq_pkg::S_SHIFT: begin
        we    = 1'b1;
        waddr = AW'(idx_r - CW'(1));
      end
      rwwq_pkg::S_DONE: begin
        ov = 1'b1;
        if (req_r.op == rwwq_pkg::OP_WAKE && nres_r != '0) begin
          of = hold_r;
        end else begin
          of.status = (req_r.op == rwwq_pkg::OP_WAKE) ? rwwq_pkg::ST_NOTFOUND : st_r;
          of.found = (req_r.op == rwwq_pkg::OP_QRY) && hit_r;
          of.queue_empty = (count_r == '0);
        end
        of.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Result register: one beat per cycle.
  logic           pend_r;
  rwwq_pkg::out_t pout_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= ov;
    end
    if (ov) begin
      pout_r <= of;
    end
  end

  always_comb begin
    out_valid  = pend_r;
    out_fields = pout_r;
  end

endmodule
`default_nettype wire
